FILE: rtl/eazd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eazd_pkg
// Shared constants, codes and types of the early-abandon z-norm distance unit.
// ---------------------------------------------------------------------------
package eazd_pkg;

    localparam int MAX_WINDOW   = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_BITS    = $clog2(MAX_WINDOW);
    localparam int LEN_BITS     = ADDR_BITS + 1;
    localparam int OFFSET_BITS  = 10;
    localparam int QV_BITS      = 16;
    localparam int SUM_BITS     = SAMPLE_BITS + ADDR_BITS + 1;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS + ADDR_BITS;
    localparam int CFG_BITS     = 32;
    localparam int DIST_BITS    = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_N_BITS   = 64;
    localparam int DIV_D_BITS   = 32;

    localparam logic [LEN_BITS-1:0]  WINDOW_LEN_RESET = LEN_BITS'(128);
    localparam logic [DIST_BITS-1:0] DIST_SAT         = '1;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_WINDOW_LEN    = 1'b0;
    localparam logic REG_ABANDON_LIMIT = 1'b1;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_ABANDON = 2'd1;
    localparam logic [1:0] STATUS_FLAT    = 2'd2;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [OFFSET_BITS-1:0]        offset;
        logic signed [QV_BITS-1:0]     query_value;
        logic                          last;
    } item_t;

    typedef struct packed {
        logic                write;
        logic                idx;
        logic [CFG_BITS-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_N_BITS-1:0] dividend;
        logic [DIV_D_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic [DIV_N_BITS-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPEN,
        PH_DROP
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RS_RD,
        S_RS_ACC,
        S_PUSH_RD,
        S_PUSH_SQ,
        S_PUSH_ACC,
        S_ST_MEAN,
        S_ST_MWAIT,
        S_ST_CMP,
        S_ST_NORM,
        S_ST_SQRT,
        S_ST_RWAIT,
        S_ST_INV,
        S_EL_CHK,
        S_EL_D,
        S_EL_M1,
        S_EL_M2,
        S_EL_Z,
        S_EL_E,
        S_EL_SQ,
        S_EL_ACC,
        S_EL_END,
        S_EMIT
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/eazd_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eazd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module eazd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/eazd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eazd_front
// Input side: accepts words and holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
module eazd_front
    import eazd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  q_pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push;
    logic                pop;

    assign in_stall = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/eazd_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eazd_div
// Restoring divider, one quotient bit per cycle, shared by the stats latch.
// ---------------------------------------------------------------------------
module eazd_div
    import eazd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_BITS = $clog2(DIV_N_BITS);

    logic                  busy_reg, busy_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [DIV_N_BITS-1:0] quo_reg, quo_next;
    logic [DIV_D_BITS-1:0] rem_reg, rem_next;
    logic [DIV_D_BITS-1:0] dvs_reg, dvs_next;
    logic [DIV_D_BITS:0]   trial;
    logic                  ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIV_N_BITS-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_D_BITS'(trial - {1'b0, dvs_reg}) : trial[DIV_D_BITS-1:0];
            quo_next = {quo_reg[DIV_N_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(DIV_N_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/eazd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eazd_back
// Execution side: sample ring, window sums, stats latch, element datapath
// and the result register.
// ---------------------------------------------------------------------------
module eazd_back
    import eazd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_wr_t  cfg,
    input  wire logic     q_valid,
    input  wire item_t    q_item,
    output logic          q_pop,
    output div_req_t      div_req,
    input  wire div_rsp_t div_rsp,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [DIST_BITS-1:0] distance,
    output logic [1:0]    status
);

    localparam int LQ_BITS   = LEN_BITS + SQ_BITS;
    localparam int S2_BITS   = 2 * SUM_BITS;
    localparam int NORM_BITS = 62;
    localparam int SH_BITS   = 5;
    localparam int Q_BITS    = 33;
    localparam int PROD_BITS = LEN_BITS + Q_BITS;
    localparam int D_BITS    = 34;
    localparam int MAG_BITS  = 32;
    localparam int PP_BITS   = 48;
    localparam int ZMAG_BITS = 36;
    localparam int E_BITS    = 38;
    localparam int SQR_BITS  = 2 * SAMPLE_BITS;

    // control and architectural state
    back_state_t            state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [LEN_BITS-1:0]    win_len_reg, win_len_next;
    logic [DIST_BITS-1:0]   limit_reg, limit_next;
    logic                   resum_pend_reg, resum_pend_next;
    logic [ADDR_BITS-1:0]   wp_reg, wp_next;
    logic                   full_reg, full_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SQ_BITS-1:0]     sq_reg, sq_next;
    logic signed [31:0]     mean_reg, mean_next;
    logic [31:0]            inv_reg, inv_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;
    logic                   out_valid_reg, out_valid_next;

    // working registers
    item_t                  cur_reg, cur_next;
    logic [LEN_BITS-1:0]    cnt_reg, cnt_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic signed [SAMPLE_BITS-1:0] old_reg, old_next;
    logic [SQR_BITS-1:0]    nsq_reg, nsq_next;
    logic [SQR_BITS-1:0]    osq_reg, osq_next;
    logic [LQ_BITS-1:0]     lq_reg, lq_next;
    logic [S2_BITS-1:0]     s2_reg, s2_next;
    logic [NORM_BITS-1:0]   norm_reg, norm_next;
    logic [SH_BITS-1:0]     sh_reg, sh_next;
    logic [NORM_BITS-1:0]   res_reg, res_next;
    logic [NORM_BITS-1:0]   bit_reg, bit_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic                   dneg_reg, dneg_next;
    logic [MAG_BITS-1:0]    mag_reg, mag_next;
    logic [PP_BITS-1:0]     plo_reg, plo_next;
    logic [PP_BITS-1:0]     phi_reg, phi_next;
    logic [ZMAG_BITS-1:0]   zmag_reg, zmag_next;
    logic [E_BITS-2:0]      emag_reg, emag_next;
    logic [DIST_BITS-1:0]   term_reg, term_next;
    logic [DIST_BITS-1:0]   pend_dist_reg, pend_dist_next;
    logic [1:0]             pend_status_reg, pend_status_next;
    logic [DIST_BITS-1:0]   out_dist_reg, out_dist_next;
    logic [1:0]             out_status_reg, out_status_next;

    // combinational helpers
    logic [LEN_BITS-1:0]    eff_len;
    logic [ADDR_BITS-1:0]   base_addr;
    logic [ADDR_BITS-1:0]   raddr;
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic                   sum_neg;
    logic [SUM_BITS-1:0]    smag;
    logic signed [SQR_BITS-1:0] sq_prod;
    logic signed [SQR_BITS-1:0] old_prod;
    logic [NORM_BITS:0]     sq_trial;
    logic [5:0]             inv_shift;
    logic [PROD_BITS-1:0]   inv_full;
    logic signed [D_BITS-1:0] dval;
    logic [63:0]            zfull;
    logic signed [E_BITS-1:0] zval;
    logic signed [E_BITS-1:0] eval_s;
    logic [PP_BITS-1:0]     esq;
    logic [DIST_BITS:0]     dsum;
    logic [DIST_BITS-1:0]   dsat;
    logic                   emit_free;

    always_comb
    begin
        if (win_len_reg == '0)
        begin
            eff_len = LEN_BITS'(1);
        end
        else if (win_len_reg > LEN_BITS'(MAX_WINDOW))
        begin
            eff_len = LEN_BITS'(MAX_WINDOW);
        end
        else
        begin
            eff_len = win_len_reg;
        end
    end

    assign base_addr = wp_reg - eff_len[ADDR_BITS-1:0];
    assign rd_sample = rd_ok_reg ? $signed(rdata) : '0;
    assign sum_neg   = sum_reg[SUM_BITS-1];
    assign smag      = sum_neg ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign emit_free = !out_valid_reg || !out_stall;

    eazd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cur_reg.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        win_len_next     = win_len_reg;
        limit_next       = limit_reg;
        resum_pend_next  = resum_pend_reg;
        wp_next          = wp_reg;
        full_next        = full_reg;
        sum_next         = sum_reg;
        sq_next          = sq_reg;
        mean_next        = mean_reg;
        inv_next         = inv_reg;
        dist_next        = dist_reg;
        out_valid_next   = out_valid_reg;
        cur_next         = cur_reg;
        cnt_next         = cnt_reg;
        rd_ok_next       = rd_ok_reg;
        old_next         = old_reg;
        nsq_next         = nsq_reg;
        osq_next         = osq_reg;
        lq_next          = lq_reg;
        s2_next          = s2_reg;
        norm_next        = norm_reg;
        sh_next          = sh_reg;
        res_next         = res_reg;
        bit_next         = bit_reg;
        prod_next        = prod_reg;
        dneg_next        = dneg_reg;
        mag_next         = mag_reg;
        plo_next         = plo_reg;
        phi_next         = phi_reg;
        zmag_next        = zmag_reg;
        emag_next        = emag_reg;
        term_next        = term_reg;
        pend_dist_next   = pend_dist_reg;
        pend_status_next = pend_status_reg;
        out_dist_next    = out_dist_reg;
        out_status_next  = out_status_reg;

        q_pop            = 1'b0;
        ram_we           = 1'b0;
        raddr            = base_addr;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        sq_prod   = rd_sample * rd_sample;
        old_prod  = '0;
        sq_trial  = {1'b0, res_reg} + {1'b0, bit_reg};
        inv_shift = 6'd38 - {1'b0, sh_reg};
        inv_full  = prod_reg >> inv_shift;
        dval      = (D_BITS'(rd_sample) <<< 16) - D_BITS'(mean_reg);
        zfull     = {phi_reg, 16'b0} + 64'(plo_reg);
        zval      = dneg_reg ? -$signed({2'b0, zmag_reg}) : $signed({2'b0, zmag_reg});
        eval_s    = zval - E_BITS'(cur_reg.query_value);
        esq       = emag_reg[23:0] * emag_reg[23:0];
        dsum      = {1'b0, dist_reg} + {1'b0, term_reg};
        dsat      = dsum[DIST_BITS] ? DIST_SAT : dsum[DIST_BITS-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (resum_pend_reg)
                begin
                    resum_pend_next = 1'b0;
                    sum_next        = '0;
                    sq_next         = '0;
                    cnt_next        = '0;
                    state_next      = S_RS_RD;
                end
                else if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.command == CMD_PUSH)
                    begin
                        state_next = S_PUSH_RD;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_DROP:
                            begin
                                if (q_item.last)
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_OPEN:
                            begin
                                state_next = S_EL_CHK;
                            end
                            default:
                            begin
                                dist_next  = '0;
                                state_next = S_ST_MEAN;
                            end
                        endcase
                    end
                end
            end

            // window resum: each entry is read in S_RS_RD and added in S_RS_ACC
            S_RS_RD:
            begin
                if (resum_pend_reg)
                begin
                    resum_pend_next = 1'b0;
                    sum_next        = '0;
                    sq_next         = '0;
                    cnt_next        = '0;
                end
                else if (cnt_reg == eff_len)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr      = base_addr + cnt_reg[ADDR_BITS-1:0];
                    rd_ok_next = full_reg || (raddr < wp_reg);
                    state_next = S_RS_ACC;
                end
            end

            S_RS_ACC:
            begin
                sum_next   = sum_reg + SUM_BITS'(rd_sample);
                sq_next    = sq_reg + SQ_BITS'($unsigned(sq_prod));
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_RS_RD;
            end

            S_PUSH_RD:
            begin
                raddr      = base_addr;
                rd_ok_next = full_reg || (base_addr < wp_reg);
                state_next = S_PUSH_SQ;
            end

            S_PUSH_SQ:
            begin
                old_prod   = $signed(cur_reg.sample) * $signed(cur_reg.sample);
                old_next   = rd_sample;
                osq_next   = $unsigned(sq_prod);
                nsq_next   = $unsigned(old_prod);
                ram_we     = 1'b1;
                wp_next    = wp_reg + 1'b1;
                if (wp_reg == ADDR_BITS'(MAX_WINDOW - 1))
                begin
                    full_next = 1'b1;
                end
                state_next = S_PUSH_ACC;
            end

            S_PUSH_ACC:
            begin
                sum_next   = sum_reg + SUM_BITS'(cur_reg.sample) - SUM_BITS'(old_reg);
                sq_next    = sq_reg + SQ_BITS'(nsq_reg) - SQ_BITS'(osq_reg);
                state_next = S_IDLE;
            end

            // stats latch at query start
            S_ST_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_BITS'({smag, 16'b0})
                                 + (sum_neg ? DIV_N_BITS'(eff_len - 1'b1) : '0);
                div_req.divisor  = DIV_D_BITS'(eff_len);
                lq_next          = LQ_BITS'(eff_len * sq_reg);
                s2_next          = smag * smag;
                state_next       = S_ST_MWAIT;
            end

            S_ST_MWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    mean_next  = sum_neg ? -$signed(div_rsp.quotient[31:0])
                                         : $signed(div_rsp.quotient[31:0]);
                    state_next = S_ST_CMP;
                end
            end

            S_ST_CMP:
            begin
                if (S2_BITS'(lq_reg) <= s2_reg)
                begin
                    inv_next         = '0;
                    phase_next       = cur_reg.last ? PH_IDLE : PH_DROP;
                    pend_dist_next   = DIST_SAT;
                    pend_status_next = STATUS_FLAT;
                    state_next       = S_EMIT;
                end
                else
                begin
                    norm_next  = NORM_BITS'(lq_reg) - NORM_BITS'(s2_reg);
                    sh_next    = '0;
                    state_next = S_ST_NORM;
                end
            end

            // two bits of left shift a cycle until the top pair is nonzero or 30 shifts are done
            S_ST_NORM:
            begin
                if ((norm_reg[NORM_BITS-1:NORM_BITS-2] == 2'b00) && (sh_reg < SH_BITS'(30)))
                begin
                    norm_next = norm_reg << 2;
                    sh_next   = sh_reg + 1'b1;
                end
                else
                begin
                    res_next   = '0;
                    bit_next   = NORM_BITS'(1) << 60;
                    state_next = S_ST_SQRT;
                end
            end

            S_ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if ({1'b0, norm_reg} >= sq_trial)
                    begin
                        norm_next = NORM_BITS'({1'b0, norm_reg} - sq_trial);
                        res_next  = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_BITS'(1) << 62;
                    div_req.divisor  = res_reg[DIV_D_BITS-1:0];
                    state_next       = S_ST_RWAIT;
                end
            end

            S_ST_RWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    prod_next  = eff_len * div_rsp.quotient[Q_BITS-1:0];
                    state_next = S_ST_INV;
                end
            end

            S_ST_INV:
            begin
                inv_next   = (inv_full[PROD_BITS-1:32] != '0) ? 32'hFFFF_FFFF : inv_full[31:0];
                phase_next = PH_OPEN;
                state_next = S_EL_CHK;
            end

            // element datapath
            S_EL_CHK:
            begin
                if (LEN_BITS'(cur_reg.offset) < eff_len)
                begin
                    raddr      = base_addr + ADDR_BITS'(cur_reg.offset);
                    rd_ok_next = full_reg || (raddr < wp_reg);
                    state_next = S_EL_D;
                end
                else
                begin
                    state_next = S_EL_END;
                end
            end

            S_EL_D:
            begin
                dneg_next  = dval[D_BITS-1];
                mag_next   = dval[D_BITS-1] ? MAG_BITS'(-dval) : MAG_BITS'(dval);
                state_next = S_EL_M1;
            end

            S_EL_M1:
            begin
                plo_next   = mag_reg * inv_reg[15:0];
                state_next = S_EL_M2;
            end

            S_EL_M2:
            begin
                phi_next   = mag_reg * inv_reg[31:16];
                state_next = S_EL_Z;
            end

            S_EL_Z:
            begin
                zmag_next  = zfull[63:28];
                state_next = S_EL_E;
            end

            S_EL_E:
            begin
                emag_next  = eval_s[E_BITS-1] ? (E_BITS-1)'(-eval_s) : (E_BITS-1)'(eval_s);
                state_next = S_EL_SQ;
            end

            S_EL_SQ:
            begin
                if (emag_reg[E_BITS-2:24] != '0)
                begin
                    term_next = DIST_SAT;
                end
                else if (esq[PP_BITS-1:40] != '0)
                begin
                    term_next = DIST_SAT;
                end
                else
                begin
                    term_next = esq[39:8];
                end
                state_next = S_EL_ACC;
            end

            S_EL_ACC:
            begin
                dist_next = dsat;
                if (dsat > limit_reg)
                begin
                    phase_next       = cur_reg.last ? PH_IDLE : PH_DROP;
                    pend_dist_next   = dsat;
                    pend_status_next = STATUS_ABANDON;
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_EL_END;
                end
            end

            S_EL_END:
            begin
                if (cur_reg.last)
                begin
                    phase_next       = PH_IDLE;
                    pend_dist_next   = dist_reg;
                    pend_status_next = STATUS_DONE;
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (emit_free)
                begin
                    out_valid_next  = 1'b1;
                    out_dist_next   = pend_dist_reg;
                    out_status_next = pend_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes win over a clear of the resum request
        if (cfg.write)
        begin
            if (cfg.idx == REG_WINDOW_LEN)
            begin
                win_len_next    = cfg.data[LEN_BITS-1:0];
                resum_pend_next = 1'b1;
            end
            else
            begin
                limit_next = cfg.data[DIST_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            win_len_reg    <= WINDOW_LEN_RESET;
            limit_reg      <= DIST_SAT;
            resum_pend_reg <= 1'b0;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            sum_reg        <= '0;
            sq_reg         <= '0;
            mean_reg       <= '0;
            inv_reg        <= '0;
            dist_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            win_len_reg    <= win_len_next;
            limit_reg      <= limit_next;
            resum_pend_reg <= resum_pend_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            sum_reg        <= sum_next;
            sq_reg         <= sq_next;
            mean_reg       <= mean_next;
            inv_reg        <= inv_next;
            dist_reg       <= dist_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        cnt_reg         <= cnt_next;
        rd_ok_reg       <= rd_ok_next;
        old_reg         <= old_next;
        nsq_reg         <= nsq_next;
        osq_reg         <= osq_next;
        lq_reg          <= lq_next;
        s2_reg          <= s2_next;
        norm_reg        <= norm_next;
        sh_reg          <= sh_next;
        res_reg         <= res_next;
        bit_reg         <= bit_next;
        prod_reg        <= prod_next;
        dneg_reg        <= dneg_next;
        mag_reg         <= mag_next;
        plo_reg         <= plo_next;
        phi_reg         <= phi_next;
        zmag_reg        <= zmag_next;
        emag_reg        <= emag_next;
        term_reg        <= term_next;
        pend_dist_reg   <= pend_dist_next;
        pend_status_reg <= pend_status_next;
        out_dist_reg    <= out_dist_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = out_dist_reg;
    assign status    = out_status_reg;

endmodule
`default_nettype wire

FILE: rtl/early_abandon_znorm_distance_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// early_abandon_znorm_distance_unit
// Early-abandoning z-normalized squared distance over a sliding sample window.
// ---------------------------------------------------------------------------
// Words enter a two-deep queue and are executed one at a time by a sequencer
// around a 1024 x 16 sample RAM with one read and one write port. A sample
// push reads the sample leaving the window, writes the new one and updates
// the window sums. A query element runs the element datapath when its offset
// lies inside the window and skips it otherwise; the last element, or one
// that abandons the query, also hands its result on. The first element of
// a query also latches window stats: two passes through the bit-serial 64-bit
// divider, up to 30 normalize steps and a 31-step square root. A write of
// window_len makes the unit resum the window, reading each window sample in
// turn, and queued words wait until that is done. The result register lets
// the next word run while a result waits to be taken.
module early_abandon_znorm_distance_unit
    import eazd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [OFFSET_BITS-1:0]        offset,
    input  wire logic signed [QV_BITS-1:0]     query_value,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [DIST_BITS-1:0]               distance,
    output logic [1:0]                         status,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [CFG_BITS-1:0]           cfg_data
);

    item_t    in_item;
    item_t    q_item;
    logic     q_valid;
    logic     q_pop;
    cfg_wr_t  cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_item.command     = command;
    assign in_item.sample      = sample;
    assign in_item.offset      = offset;
    assign in_item.query_value = query_value;
    assign in_item.last        = last;

    assign cfg.write = cfg_write;
    assign cfg.idx   = cfg_index;
    assign cfg.data  = cfg_data;

    eazd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    eazd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    eazd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance),
        .status    (status)
    );

`ifndef SYNTHESIS
    // flat window always reports a saturated distance
    a_flat_sat : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FLAT)) |-> (distance == DIST_SAT))
        else $error("flat result without saturated distance");

    // abandon needs distance above the limit, so never zero
    a_abandon_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_ABANDON)) |-> (distance != '0))
        else $error("abandon result with zero distance");

    // the divider is only started while idle
    a_div_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the early-abandon z-norm distance unit: a queue-fed
// driver, a result monitor and a bit-true predictor of window stats, per-word
// distance terms and the done / abandon / flat outcomes, across several
// window_len and abandon_limit settings.
// ---------------------------------------------------------------------------
module tb;
    import eazd_pkg::*;

    typedef struct {
        logic [DIST_BITS-1:0] dist_val;
        logic [1:0]           st;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic [OFFSET_BITS-1:0] offset = '0;
    logic signed [QV_BITS-1:0] query_value = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DIST_BITS-1:0] distance;
    logic [1:0] status;
    logic cfg_write = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    item_t   pending_words[$];
    result_t expected_results[$];
    int errors = 0;
    int sent_words = 0;
    int got_results = 0;
    int stall_words = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // predictor state
    longint      ring[MAX_WINDOW];
    int unsigned wptr;
    bit [63:0]   wsum, wsq;
    longint      wmean;
    bit [63:0]   inv_dev, run_dist, limit_reg;
    phase_t      qphase;
    int unsigned wlen;

    early_abandon_znorm_distance_unit dut (.*);

    initial forever #6 clk = ~clk;

    function automatic int unsigned eff_len();
        if (wlen == 0) return 1;
        if (wlen > MAX_WINDOW) return MAX_WINDOW;
        return wlen;
    endfunction

    function automatic int unsigned ring_slot(int unsigned k);
        return (wptr + MAX_WINDOW - eff_len() + k) % MAX_WINDOW;
    endfunction

    function automatic void resum();
        bit [63:0] v;
        wsum = 0;
        wsq = 0;
        for (int unsigned k = 0; k < eff_len(); k++)
        begin
            v = ring[ring_slot(k)];
            wsum += v;
            wsq += v * v;
        end
    endfunction

    function automatic bit [63:0] isqrt(bit [63:0] n);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic bit latch_stats();
        bit [63:0] len, smag, lq, s2, n, r, q, inv;
        bit neg;
        int unsigned s;
        len = eff_len();
        neg = wsum[63];
        smag = neg ? -wsum : wsum;
        lq = len * wsq;
        s2 = smag * smag;
        s = 0;
        if (neg) wmean = -longint'(((smag << 16) + len - 1) / len);
        else wmean = longint'((smag << 16) / len);
        if (lq <= s2)
        begin
            inv_dev = 0;
            return 1'b0;
        end
        n = lq - s2;
        while (s < 60 && n < (64'd1 << (60 - s))) s += 2;
        r = isqrt(n << s);
        if (r == 0) r = 1;
        q = (64'd1 << 62) / r;
        inv = (len * q) >> (38 - s / 2);
        inv_dev = (inv > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : inv;
        return 1'b1;
    endfunction

    function automatic bit [63:0] dist_term(int unsigned k, longint qv);
        longint x, d, z, e;
        bit [63:0] dm, zmag, em, t;
        x = ring[ring_slot(k)];
        d = x * 65536 - wmean;
        dm = (d < 0) ? -d : d;
        zmag = (dm * inv_dev) >> 28;
        z = (d < 0) ? -longint'(zmag) : longint'(zmag);
        e = z - qv;
        em = (e < 0) ? -e : e;
        if (em >= (64'd1 << 24)) return 64'hFFFF_FFFF;
        t = (em * em) >> 8;
        return (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
    endfunction

    function automatic void add_result(bit [63:0] d, logic [1:0] st);
        result_t r;
        r.dist_val = d[31:0];
        r.st = st;
        expected_results = {expected_results, r};
    endfunction

    function automatic void predict_word(item_t w);
        longint x, old;
        bit [63:0] xv, ov;
        if (w.command == CMD_PUSH)
        begin
            x = w.sample;
            old = ring[(wptr + MAX_WINDOW - eff_len()) % MAX_WINDOW];
            xv = x;
            ov = old;
            wsum = wsum + xv - ov;
            wsq = wsq + xv * xv - ov * ov;
            ring[wptr] = x;
            wptr = (wptr + 1) % MAX_WINDOW;
            return;
        end
        if (qphase == PH_DROP)
        begin
            if (w.last) qphase = PH_IDLE;
            return;
        end
        if (qphase != PH_OPEN)
        begin
            run_dist = 0;
            if (!latch_stats())
            begin
                qphase = w.last ? PH_IDLE : PH_DROP;
                add_result(64'hFFFF_FFFF, STATUS_FLAT);
                return;
            end
            qphase = PH_OPEN;
        end
        if (w.offset < eff_len())
        begin
            run_dist += dist_term(w.offset, longint'(w.query_value));
            if (run_dist > 64'hFFFF_FFFF) run_dist = 64'hFFFF_FFFF;
            if (run_dist > limit_reg)
            begin
                qphase = w.last ? PH_IDLE : PH_DROP;
                add_result(run_dist, STATUS_ABANDON);
                return;
            end
        end
        if (w.last)
        begin
            qphase = PH_IDLE;
            add_result(run_dist, STATUS_DONE);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_word('{command, sample, offset, query_value, last});
                sent_words++;
            end
            else if (in_valid)
                stall_words++;
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 &&
                    ((sent_words >= 250 && sent_words < 400) || $urandom_range(0, 99) >= 33))
                begin
                    {command, sample, offset, query_value, last} <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off to back the unit up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && sent_words >= 450)
            begin
                hold_done <= 1'b1;
                hold_cnt <= 400;
                out_stall <= 1'b1;
            end
            else if (sent_words >= 250 && sent_words < 400)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 33);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            got_results++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", distance, 0);
            else
            begin
                r = expected_results.pop_front();
                if (distance !== r.dist_val) report_mismatch("distance", distance, r.dist_val);
                if (status !== r.st) report_mismatch("status", status, r.st);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("early_abandon_znorm_distance_unit verification failed");
            $finish;
        end
    end

    task automatic add_word(logic cmd, logic [15:0] smp, logic [9:0] off,
                            logic [15:0] qv, logic lst);
        item_t w;
        w.command = cmd;
        w.sample = smp;
        w.offset = off;
        w.query_value = qv;
        w.last = lst;
        pending_words = {pending_words, w};
    endtask

    task automatic write_reg(logic idx, logic [31:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_WINDOW_LEN)
        begin
            wlen = v[10:0];
            resum();
        end
        else
            limit_reg = v;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        // pushes give no result; cover a resum of the largest window
        repeat (2500) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_qv();
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 16383)) - 16'd8192;
        return 16'($urandom);
    endfunction

    task automatic random_phase(int unsigned len, int count);
        int n, made;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) add_word(CMD_PUSH, 16'($urandom), 10'($urandom),
                                        16'($urandom), 1'($urandom));
                    made += n;
                end
                4, 5, 6, 7, 8:
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            add_word(CMD_PUSH, 16'($urandom), 10'($urandom), 16'($urandom),
                                     1'b0);
                            made++;
                        end
                        add_word(CMD_QUERY, 16'($urandom),
                                 ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(0, len - 1)),
                                 pick_qv(), i == n - 1);
                    end
                    made += n;
                end
                default:
                begin
                    add_word(1'($urandom), 16'($urandom), 10'($urandom), 16'($urandom),
                             1'($urandom));
                    made++;
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned lens[7];
        logic [31:0] limits[7];
        int unsigned e;
        lens = '{0, 1, 2047, 1024, 5, 16, 128};
        limits = '{32'hFFFF_FFFF, $urandom, 32'd0, 32'hFFFF_FFFF, 32'd100000,
                   $urandom_range(0, 32'h00FF_FFFF), $urandom};
        foreach (ring[i]) ring[i] = 0;
        wptr = 0;
        wsum = 0;
        wsq = 0;
        wmean = 0;
        inv_dev = 0;
        run_dist = 0;
        qphase = PH_IDLE;
        wlen = 128;
        limit_reg = 64'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // flat window right after reset: rest of the query dropped
        add_word(CMD_QUERY, 16'd0, 10'd0, 16'h7FFF, 1'b0);
        add_word(CMD_QUERY, 16'd0, 10'd5, 16'h8000, 1'b0);
        add_word(CMD_QUERY, 16'd0, 10'd6, 16'd0, 1'b1);
        add_word(CMD_QUERY, 16'd0, 10'd1, 16'd0, 1'b1);
        add_word(CMD_PUSH, 16'h7FFF, 10'h3FF, 16'hFFFF, 1'b1);
        add_word(CMD_PUSH, 16'h8000, 10'd0, 16'd0, 1'b0);
        add_word(CMD_PUSH, 16'd0, 10'd0, 16'd0, 1'b0);
        add_word(CMD_PUSH, 16'd1234, 10'd0, 16'd0, 1'b0);
        add_word(CMD_PUSH, 16'hFFFF, 10'd0, 16'd0, 1'b0);
        // offsets at the window edges, one beyond it, extreme query values
        add_word(CMD_QUERY, 16'd0, 10'd127, 16'h7FFF, 1'b0);
        add_word(CMD_QUERY, 16'd0, 10'd126, 16'h8000, 1'b0);
        add_word(CMD_QUERY, 16'd0, 10'h3FF, 16'd0, 1'b0);
        add_word(CMD_PUSH, 16'd77, 10'd0, 16'd0, 1'b0);
        add_word(CMD_QUERY, 16'd0, 10'd0, 16'd4096, 1'b1);
        add_word(CMD_QUERY, 16'd0, 10'd128, 16'd0, 1'b1);
        random_phase(128, 50);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            write_reg(REG_WINDOW_LEN, lens[p]);
            write_reg(REG_ABANDON_LIMIT, limits[p]);
            e = (lens[p] == 0) ? 1 : (lens[p] > MAX_WINDOW) ? MAX_WINDOW : lens[p];
            // fill a large window so it is not mostly stale samples
            if (e >= 64)
                for (int i = 0; i < 40; i++)
                    add_word(CMD_PUSH, 16'($urandom), 10'($urandom), 16'($urandom), 1'b0);
            random_phase(e, 60);
        end
        drain();

        $display("run: %0d words sent (%0d stalled cycles), %0d results checked",
                 sent_words, stall_words, got_results);
        $display("covered window lengths 0..2047 and abandon limits 0..max");
        if (errors == 0 && expected_results.size() == 0)
            $display("early_abandon_znorm_distance_unit verification clean");
        else
            $display("early_abandon_znorm_distance_unit verification failed");
        $finish;
    end

endmodule
